/* sv/crs_pkg.sv */
package crs_pkg;

  // Fixed field widths
  localparam int REQ_BITS       = 4;
  localparam int CFG_BITS       = 5;
  localparam int CFG_IDX_BITS   = 1;

  // Requester count limit and finish counter ceiling
  localparam int MAX_REQUESTERS = 16;
  localparam int FINISHED_MAX   = 31;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CAPACITY   = 1'b0,
    CFG_REQUESTERS = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    CMD_POST   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_SERVED   = 1'b0,
    ST_REJECTED = 1'b1
  } status_t;

endpackage

/* sv/crs_in_if.sv */
interface crs_in_if #(
  parameter int POSITION_BITS = 10
);
  import crs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [REQ_BITS-1:0]      requester;
  logic [POSITION_BITS-1:0] position;

  modport source (output valid, command, requester, position, input ready);
  modport sink   (input valid, command, requester, position, output ready);
endinterface

/* sv/crs_out_if.sv */
interface crs_out_if #(
  parameter int POSITION_BITS = 10
);
  import crs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     status;
  logic [REQ_BITS-1:0]      served_requester;
  logic [POSITION_BITS-1:0] served_position;

  modport source (output valid, status, served_requester, served_position, input ready);
  modport sink   (input valid, status, served_requester, served_position, output ready);
endinterface

/* sv/crs_ram.sv */
module crs_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/closest_request_scheduler_core.sv */
// Shortest-seek-first request board. Each input transfer is either a post
// (requester id and position) or a requester-finished event. Posts are kept
// in arrival order in a single-port-write, registered-read RAM. After each
// stored post or finish event the board is checked: when the active count
// (num_requesters, limited to 16, minus finished events) is nonzero and the
// occupancy has reached the smaller of capacity and active count, the entry
// closest to the last served position (-1 after reset, ties to the earliest
// arrival) is removed and sent out with status 0. A post onto a full board
// is dropped and answered at once with status 1. Only one item is in work
// at a time; a reject or a serve waits in S_EMIT while the output stalls.
// A serve does one RAM read per cycle for the distance scan, then one read
// and one write per cycle to close the gap behind the served entry. The
// output register lets the next item enter while a result waits.
module closest_request_scheduler_core #(
  parameter int BOARD_DEPTH   = 16,
  parameter int POSITION_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  crs_in_if.sink                                  in_chan,
  crs_out_if.source                               out_chan,
  input  logic                                    cfg_we,
  input  logic [crs_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [crs_pkg::CFG_BITS-1:0]            cfg_wdata
);
  import crs_pkg::*;

  localparam int IDX_W   = BOARD_DEPTH > 1 ? $clog2(BOARD_DEPTH) : 1;
  localparam int CNT_W   = $clog2(BOARD_DEPTH + 1);
  localparam int CMP_W   = CNT_W > CFG_BITS ? CNT_W : CFG_BITS;
  localparam int DIST_W  = POSITION_BITS + 1;
  localparam int ENTRY_W = REQ_BITS + POSITION_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state_r;

  // config registers
  logic [CFG_BITS-1:0]      cap_r;
  logic [CFG_BITS-1:0]      num_r;

  // board bookkeeping
  logic [CNT_W-1:0]         count_r;
  logic [POSITION_BITS-1:0] last_r;
  logic                     have_last_r;
  logic [CFG_BITS-1:0]      fin_r;

  // scan state
  logic [CNT_W-1:0]         scan_r;
  logic                     dvld_r;
  logic [IDX_W-1:0]         didx_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [DIST_W-1:0]        best_d_r;
  logic [ENTRY_W-1:0]       best_ent_r;

  // shift state
  logic [CNT_W-1:0]         rd_ptr_r;
  logic                     pvld_r;
  logic [IDX_W-1:0]         pidx_r;

  // pending result and output register
  logic                     res_status_r;
  logic [REQ_BITS-1:0]      res_rq_r;
  logic [POSITION_BITS-1:0] res_ps_r;
  logic                     out_valid_r;
  logic                     out_status_r;
  logic [REQ_BITS-1:0]      out_rq_r;
  logic [POSITION_BITS-1:0] out_ps_r;

  // RAM ports
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic                     in_xfer;
  logic                     slot_free;
  logic [CMP_W-1:0]         cap_eff;
  logic [CMP_W-1:0]         count_ext;
  logic [CFG_BITS-1:0]      num_eff;
  logic [CFG_BITS-1:0]      act;
  logic [CMP_W-1:0]         need;
  logic                     board_full;
  logic                     serve_go;
  logic                     scan_issue;
  logic                     shift_issue;
  logic [DIST_W-1:0]        rd_dist;

  function automatic logic [DIST_W-1:0] seek_dist(
    input logic [POSITION_BITS-1:0] pos,
    input logic [POSITION_BITS-1:0] last,
    input logic                     have
  );
    logic [DIST_W-1:0] d;
    if (!have) begin
      d = DIST_W'(pos) + DIST_W'(1);
    end else if (pos >= last) begin
      d = DIST_W'(pos - last);
    end else begin
      d = DIST_W'(last - pos);
    end
    return d;
  endfunction

  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.served_requester = out_rq_r;
  assign out_chan.served_position  = out_ps_r;

  // effective capacity, active count and serve threshold
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(BOARD_DEPTH)) begin
      cap_eff = CMP_W'(BOARD_DEPTH);
    end
    num_eff = (num_r > CFG_BITS'(MAX_REQUESTERS)) ? CFG_BITS'(MAX_REQUESTERS) : num_r;
    act     = (num_eff > fin_r) ? num_eff - fin_r : '0;
    need    = (cap_eff < CMP_W'(act)) ? cap_eff : CMP_W'(act);
  end

  assign count_ext  = CMP_W'(count_r);
  assign board_full = (count_ext >= cap_eff);
  assign serve_go   = (act != '0) && (count_r != '0) && (count_ext >= need);

  assign scan_issue  = (state_r == S_SCAN) && (scan_r < count_r);
  assign shift_issue = (state_r == S_SHIFT) && (rd_ptr_r < count_r);
  assign rd_dist     = seek_dist(ram_rdata[POSITION_BITS-1:0], last_r, have_last_r);

  // RAM access steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = {in_chan.requester, in_chan.position};
    ram_re    = 1'b0;
    ram_raddr = scan_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        ram_we = in_xfer && (in_chan.command == CMD_POST) && !board_full;
      end
      S_SCAN: begin
        ram_re = scan_issue;
      end
      S_SHIFT: begin
        ram_re    = shift_issue;
        ram_raddr = rd_ptr_r[IDX_W-1:0];
        // write back what was read last cycle one slot lower
        ram_we    = pvld_r;
        ram_waddr = pidx_r;
        ram_wdata = ram_rdata;
      end
      S_CHECK, S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  crs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BOARD_DEPTH)
  ) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CFG_BITS'(3);
      num_r       <= CFG_BITS'(4);
      count_r     <= '0;
      last_r      <= '0;
      have_last_r <= 1'b0;
      fin_r       <= '0;
      scan_r      <= '0;
      dvld_r      <= 1'b0;
      rd_ptr_r    <= '0;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CAPACITY:   cap_r <= cfg_wdata;
          CFG_REQUESTERS: num_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // drained output; a reload from S_EMIT takes over below
      if (out_valid_r && out_chan.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_chan.command == CMD_POST) begin
              if (board_full) begin
                res_status_r <= ST_REJECTED;
                res_rq_r     <= in_chan.requester;
                res_ps_r     <= in_chan.position;
                state_r      <= S_EMIT;
              end else begin
                count_r <= count_r + CNT_W'(1);
                state_r <= S_CHECK;
              end
            end else begin
              if (fin_r != CFG_BITS'(FINISHED_MAX)) begin
                fin_r <= fin_r + CFG_BITS'(1);
              end
              state_r <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          scan_r <= '0;
          dvld_r <= 1'b0;
          state_r <= serve_go ? S_SCAN : S_IDLE;
        end

        S_SCAN: begin
          if (scan_issue) begin
            scan_r <= scan_r + CNT_W'(1);
            didx_r <= scan_r[IDX_W-1:0];
            dvld_r <= 1'b1;
          end else begin
            dvld_r <= 1'b0;
          end
          // strict less-than keeps the earliest arrival on ties
          if (dvld_r && (didx_r == '0 || rd_dist < best_d_r)) begin
            best_idx_r <= didx_r;
            best_d_r   <= rd_dist;
            best_ent_r <= ram_rdata;
          end
          if (!scan_issue && !dvld_r) begin
            rd_ptr_r <= CNT_W'(best_idx_r) + CNT_W'(1);
            pvld_r   <= 1'b0;
            state_r  <= S_SHIFT;
          end
        end

        S_SHIFT: begin
          if (shift_issue) begin
            rd_ptr_r <= rd_ptr_r + CNT_W'(1);
            pidx_r   <= IDX_W'(rd_ptr_r - CNT_W'(1));
            pvld_r   <= 1'b1;
          end else begin
            pvld_r <= 1'b0;
          end
          if (!shift_issue && !pvld_r) begin
            count_r      <= count_r - CNT_W'(1);
            last_r       <= best_ent_r[POSITION_BITS-1:0];
            have_last_r  <= 1'b1;
            res_status_r <= ST_SERVED;
            res_rq_r     <= best_ent_r[ENTRY_W-1:POSITION_BITS];
            res_ps_r     <= best_ent_r[POSITION_BITS-1:0];
            state_r      <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_rq_r     <= res_rq_r;
            out_ps_r     <= res_ps_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
